// ===== hdl/rtt_pkg.sv =====
// Shared types and constants of the repeating timer table.
package rtt_pkg;

  typedef enum logic [1:0] {
    ACT_TICK     = 2'd0,
    ACT_ADD      = 2'd1,
    ACT_KILL     = 2'd2,
    ACT_KILL_ALL = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    KIND_ADDED   = 3'd0,
    KIND_KILLED  = 3'd1,
    KIND_CLEARED = 3'd2,
    KIND_FIRED   = 3'd3,
    KIND_IDLE    = 3'd4
  } kind_e;

  // Classified command word as it waits in the queue.
  typedef struct packed {
    action_e     action;
    logic [15:0] elapsed;
    logic        infinite;
    logic [15:0] count;
    logic [30:0] period;
    logic [31:0] target;
  } cmd_t;

  // One timer entry of the table.
  typedef struct packed {
    logic [31:0] id;
    logic        infinite;
    logic [15:0] remaining;
    logic [30:0] period;
    logic [47:0] due;
  } slot_t;

  localparam int MAX_RESULTS = 16;
  localparam int FIRE_IDX_W  = 4;
  localparam int FIRE_CNT_W  = 5;
  localparam logic [30:0] MS_CAP   = 31'h7fff_ffff;
  localparam logic [31:0] ID_FIRST = 32'd1;

endpackage

// ===== hdl/rtt_cmd_queue.sv =====
// Front part: classifies incoming commands and holds them in a two-entry queue.
module rtt_cmd_queue
  import rtt_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  logic [1:0]  action_i,
  input  logic [15:0] elapsed_ms_i,
  input  logic [16:0] repeat_count_i,
  input  logic [30:0] period_ms_i,
  input  logic [31:0] target_id_i,
  output logic        full_o,
  output logic        valid_o,
  output cmd_t        head_o,
  input  logic        pop_i
);

  cmd_t       entry_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  cmd_t       cmd;

  always_comb begin
    cmd.action   = action_e'(action_i);
    cmd.elapsed  = elapsed_ms_i;
    // Any negative repeat count means the timer never runs out.
    cmd.infinite = repeat_count_i[16];
    cmd.count    = repeat_count_i[15:0];
    cmd.period   = period_ms_i;
    cmd.target   = target_id_i;
  end

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign head_o  = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = ~wr_ptr_q;
    end
    if (pop_i) begin
      rd_ptr_d = ~rd_ptr_q;
    end
    cnt_d = cnt_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= cmd;
    end
  end

endmodule

// ===== hdl/rtt_engine.sv =====
// Back part: timer table memory, scan sequencer and result emitter.
module rtt_engine
  import rtt_pkg::*;
#(
  parameter int SLOTS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cmd_valid_i,
  input  cmd_t        cmd_i,
  output logic        cmd_pop_o,
  output logic        result_valid_o,
  output logic [2:0]  kind_o,
  output logic [31:0] timer_id_o,
  output logic        ok_o,
  output logic [31:0] ms_to_next_o,
  output logic        last_o
);

  localparam int IDX_W = $clog2(SLOTS > 1 ? SLOTS : 2);
  localparam int CNT_W = $clog2(SLOTS + 1);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_PREP = 5'b00010,
    ST_RD   = 5'b00100,
    ST_PROC = 5'b01000,
    ST_EMIT = 5'b10000
  } state_e;

  state_e           state_q, state_d;
  cmd_t             cmd_q;
  logic [47:0]      now_q;
  logic [31:0]      next_id_q;
  logic [CNT_W-1:0] n_q, i_q, j_q;
  logic             found_q, full_q;
  logic [30:0]      best_q;
  logic [FIRE_CNT_W-1:0] k_q, e_q;
  logic [31:0]      fire_id_q [MAX_RESULTS];

  slot_t            mem [SLOTS];
  slot_t            rd_q;
  logic             mem_we;
  logic [IDX_W-1:0] mem_wa;
  slot_t            mem_wd;

  logic             is_tick, is_kill;
  logic [47:0]      dd, dn;
  logic             due_hit, match, keep;
  slot_t            upd;

  logic             res_valid_q;
  logic [2:0]       res_kind_q;
  logic [31:0]      res_id_q, res_ms_q;
  logic             res_ok_q, res_last_q;
  logic             emit_last;

  assign is_tick = (cmd_q.action == ACT_TICK);
  assign is_kill = (cmd_q.action == ACT_KILL);

  // Per-slot work of the scan: fire, reschedule, drop and track the earliest due.
  always_comb begin
    upd     = rd_q;
    dd      = rd_q.due - now_q;
    due_hit = is_tick && ((dd == 48'd0) || dd[47]);
    if (due_hit) begin
      if (!rd_q.infinite && (rd_q.remaining != 16'd0)) begin
        upd.remaining = rd_q.remaining - 16'd1;
      end
      upd.due = now_q + {17'd0, rd_q.period};
    end
    match = is_kill && !found_q && (rd_q.id == cmd_q.target);
    if (match) begin
      keep = 1'b0;
    end else if (is_tick) begin
      keep = upd.infinite || (upd.remaining != 16'd0);
    end else begin
      keep = 1'b1;
    end
    dn = upd.due - now_q;
  end

  always_comb begin
    mem_we = 1'b0;
    mem_wa = j_q[IDX_W-1:0];
    mem_wd = upd;
    if (state_q == ST_PREP && cmd_q.action == ACT_ADD && !(n_q == CNT_W'(SLOTS))) begin
      mem_we         = 1'b1;
      mem_wa         = n_q[IDX_W-1:0];
      mem_wd.id       = next_id_q;
      mem_wd.infinite = cmd_q.infinite;
      mem_wd.remaining = cmd_q.count;
      mem_wd.period   = cmd_q.period;
      mem_wd.due      = now_q + {17'd0, cmd_q.period};
    end else if (state_q == ST_PROC && keep) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_q <= mem[i_q[IDX_W-1:0]];
  end

  assign emit_last = (is_tick && k_q != '0) ? (e_q == k_q - FIRE_CNT_W'(1)) : 1'b1;
  assign cmd_pop_o = (state_q == ST_IDLE) && cmd_valid_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (cmd_valid_i) state_d = ST_PREP;
      ST_PREP: state_d = ST_RD;
      ST_RD:   state_d = (i_q < n_q) ? ST_PROC : ST_EMIT;
      ST_PROC: state_d = ST_RD;
      ST_EMIT: if (emit_last) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      now_q       <= 48'd0;
      next_id_q   <= ID_FIRST;
      n_q         <= '0;
      i_q         <= '0;
      j_q         <= '0;
      found_q     <= 1'b0;
      full_q      <= 1'b0;
      best_q      <= MS_CAP;
      k_q         <= '0;
      e_q         <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
        end
        ST_PREP: begin
          i_q     <= '0;
          j_q     <= '0;
          found_q <= 1'b0;
          best_q  <= MS_CAP;
          k_q     <= '0;
          e_q     <= '0;
          full_q  <= 1'b0;
          unique case (cmd_q.action)
            ACT_TICK: now_q <= now_q + {32'd0, cmd_q.elapsed};
            ACT_ADD: begin
              if (n_q == CNT_W'(SLOTS)) begin
                full_q <= 1'b1;
              end else begin
                n_q       <= n_q + CNT_W'(1);
                next_id_q <= next_id_q + 32'd1;
              end
            end
            ACT_KILL: begin
            end
            ACT_KILL_ALL: n_q <= '0;
            default: begin
            end
          endcase
        end
        ST_RD: begin
          if (!(i_q < n_q)) begin
            n_q <= j_q;
          end
        end
        ST_PROC: begin
          i_q <= i_q + CNT_W'(1);
          if (match) begin
            found_q <= 1'b1;
          end
          if (due_hit && k_q < FIRE_CNT_W'(MAX_RESULTS)) begin
            k_q <= k_q + FIRE_CNT_W'(1);
          end
          if (keep) begin
            j_q <= j_q + CNT_W'(1);
            if (dn[47]) begin
              best_q <= 31'd0;
            end else if (dn < {17'd0, best_q}) begin
              best_q <= dn[30:0];
            end
          end
        end
        ST_EMIT: begin
          res_valid_q <= 1'b1;
          e_q         <= e_q + FIRE_CNT_W'(1);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && cmd_valid_i) begin
      cmd_q <= cmd_i;
    end
    if (state_q == ST_PROC && due_hit && k_q < FIRE_CNT_W'(MAX_RESULTS)) begin
      fire_id_q[k_q[FIRE_IDX_W-1:0]] <= rd_q.id;
    end
    if (state_q == ST_EMIT) begin
      res_last_q <= emit_last;
      res_ms_q   <= (n_q == '0) ? 32'hffff_ffff : {1'b0, best_q};
      unique case (cmd_q.action)
        ACT_ADD: begin
          res_kind_q <= KIND_ADDED;
          res_id_q   <= full_q ? 32'd0 : next_id_q - 32'd1;
          res_ok_q   <= !full_q;
        end
        ACT_KILL: begin
          res_kind_q <= KIND_KILLED;
          res_id_q   <= cmd_q.target;
          res_ok_q   <= found_q;
        end
        ACT_KILL_ALL: begin
          res_kind_q <= KIND_CLEARED;
          res_id_q   <= 32'd0;
          res_ok_q   <= 1'b1;
        end
        default: begin
          res_ok_q <= 1'b1;
          if (k_q == '0) begin
            res_kind_q <= KIND_IDLE;
            res_id_q   <= 32'd0;
          end else begin
            res_kind_q <= KIND_FIRED;
            res_id_q   <= fire_id_q[e_q[FIRE_IDX_W-1:0]];
          end
        end
      endcase
    end
  end

  assign result_valid_o = res_valid_q;
  assign kind_o         = res_kind_q;
  assign timer_id_o     = res_id_q;
  assign ok_o           = res_ok_q;
  assign ms_to_next_o   = res_ms_q;
  assign last_o         = res_last_q;

`ifndef SYNTHESIS
  // The table never holds more timers than it has slots.
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= CNT_W'(SLOTS))
    else $error("timer count exceeds slots");

  // Compaction writes never overtake the read position.
  a_compact_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    j_q <= i_q)
    else $error("compaction write ahead of scan");

  // A result strobe follows only an emit cycle.
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> $past(state_q) == ST_EMIT)
    else $error("result without emit");

  // No command is taken while results are still being delivered.
  a_no_pop_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> !cmd_pop_o)
    else $error("command taken during emit");
`endif

endmodule

// ===== hdl/repeating_timer_table_core.sv =====
// Top level of the repeating timer table: command queue and table engine.
//
//   Channel   Handshake                         Words
//   command   start_i / busy_o                  action, elapsed, count, period, target
//   result    result_valid_o (one-cycle strobe) kind, timer_id, ok, ms_to_next, last
//
// A command word is taken when start_i is high and busy_o is low; two words can wait in
// the queue while the engine works. The engine handles one word at a time: setup in the
// IDLE and PREP states, then a read state (ST_RD, one memory read) and a process state
// (ST_PROC, process/write) per occupied slot for the table scan, a final ST_RD that
// closes the scan, then ST_EMIT for each result; each result strobe comes in the
// cycle after its emit cycle. Reset clears the time counter, the id counter and the fill
// count; slot contents are not cleared. The receiver cannot stall the result strobe.
module repeating_timer_table_core
  import rtt_pkg::*;
#(
  parameter int TIMER_SLOTS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  action_i,
  input  logic [15:0] elapsed_ms_i,
  input  logic [16:0] repeat_count_i,
  input  logic [30:0] period_ms_i,
  input  logic [31:0] target_id_i,
  output logic        result_valid_o,
  output logic [2:0]  kind_o,
  output logic [31:0] timer_id_o,
  output logic        ok_o,
  output logic [31:0] ms_to_next_o,
  output logic        last_o
);

  logic q_full, q_valid, q_pop;
  cmd_t q_head;

  // The queue is full exactly when no further word may be taken.
  assign busy_o = q_full;

  rtt_cmd_queue u_queue (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (start_i && !q_full),
    .action_i       (action_i),
    .elapsed_ms_i   (elapsed_ms_i),
    .repeat_count_i (repeat_count_i),
    .period_ms_i    (period_ms_i),
    .target_id_i    (target_id_i),
    .full_o         (q_full),
    .valid_o        (q_valid),
    .head_o         (q_head),
    .pop_i          (q_pop)
  );

  rtt_engine #(
    .SLOTS (TIMER_SLOTS)
  ) u_engine (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_valid_i    (q_valid),
    .cmd_i          (q_head),
    .cmd_pop_o      (q_pop),
    .result_valid_o (result_valid_o),
    .kind_o         (kind_o),
    .timer_id_o     (timer_id_o),
    .ok_o           (ok_o),
    .ms_to_next_o   (ms_to_next_o),
    .last_o         (last_o)
  );

endmodule
